@@ rtl/core/sofrx_pkg.sv @@
// Shared types and constants for the start-of-frame/length frame receiver.
// No dependencies; imported by every module of the receiver.
`default_nettype none

package sofrx_pkg;

    // Widest index/length the receiver supports (payload buffer up to 64 bytes)
    localparam int LEN_W = 7;

    localparam logic [7:0] START_BYTE_RST = 8'd170;
    localparam logic [5:0] MAX_LENGTH_RST = 6'd32;

    // Configuration register indexes
    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_MAX_LENGTH = 1'b1;

    // Header of a frame that passed its check
    typedef struct packed {
        logic [7:0]       frame_type;
        logic [7:0]       device_id;
        logic [LEN_W-1:0] length;
    } t_frame_desc;

    // Payload buffer write from the parser
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [LEN_W-1:0] idx;
        logic [7:0]       data;
    } t_pl_wr;

    // Frame push from the parser into the frame queue
    typedef struct packed {
        logic        valid;
        t_frame_desc desc;
    } t_frame_push;

    // Frame queue status
    typedef struct packed {
        logic        full;
        logic        empty;
        logic        wbank;
        t_frame_desc head;
    } t_fq_stat;

    // Drain side requests into the buffer
    typedef struct packed {
        logic             pop;
        logic [LEN_W-1:0] rd_idx;
    } t_drain_req;

endpackage

`default_nettype wire

@@ rtl/core/sofrx_front.sv @@
// Frame parser: hunts for the start byte, reads header and length, writes
// payload into the buffer and checks the XOR byte. Depends on sofrx_pkg.
`default_nettype none

module sofrx_front #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire                       i_cfg_idx,
    input  wire  [7:0]                i_cfg_wdata,
    input  wire                       i_accept,
    input  wire  [7:0]                i_rx_byte,
    input  wire                       i_bank,
    output sofrx_pkg::t_pl_wr         o_pl_wr,
    output sofrx_pkg::t_frame_push    o_push
);
    import sofrx_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_ID     = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_LEN_HI = 3'd4,
        PH_DATA   = 3'd5,
        PH_CHECK  = 3'd6
    } t_phase;

    t_phase           r_phase;
    logic [7:0]       r_start;
    logic [5:0]       r_maxlen;
    logic [7:0]       r_type;
    logic [7:0]       r_id;
    logic [7:0]       r_len_lo;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_idx;
    logic [7:0]       r_xor;

    logic [15:0]      len16;
    logic             too_long;
    logic [LEN_W-1:0] idx_inc;

    assign len16    = {i_rx_byte, r_len_lo};
    assign too_long = (len16 > 16'(r_maxlen)) || (len16 > 16'(MAX_PAYLOAD));
    assign idx_inc  = r_idx + 1'b1;

    always_comb begin
        o_pl_wr.en   = i_accept && (r_phase == PH_DATA);
        o_pl_wr.bank = i_bank;
        o_pl_wr.idx  = r_idx;
        o_pl_wr.data = i_rx_byte;

        o_push.valid           = i_accept && (r_phase == PH_CHECK) && (r_xor == i_rx_byte);
        o_push.desc.frame_type = r_type;
        o_push.desc.device_id  = r_id;
        o_push.desc.length     = r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_start  <= START_BYTE_RST;
            r_maxlen <= MAX_LENGTH_RST;
            r_xor    <= 8'd0;
            r_idx    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_START_BYTE: r_start  <= i_cfg_wdata;
                    REG_MAX_LENGTH: r_maxlen <= i_cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (i_rx_byte == r_start) begin
                            r_xor   <= 8'd0;
                            r_phase <= PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        r_type  <= i_rx_byte;
                        r_xor   <= r_xor ^ i_rx_byte;
                        r_phase <= PH_ID;
                    end
                    PH_ID: begin
                        r_id    <= i_rx_byte;
                        r_xor   <= r_xor ^ i_rx_byte;
                        r_phase <= PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        r_len_lo <= i_rx_byte;
                        r_xor    <= r_xor ^ i_rx_byte;
                        r_phase  <= PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        r_len <= LEN_W'(len16);
                        r_xor <= r_xor ^ i_rx_byte;
                        r_idx <= '0;
                        // drop oversize frames without waiting for a check byte
                        if (too_long) begin
                            r_phase <= PH_HUNT;
                        end else if (len16 == 16'd0) begin
                            r_phase <= PH_CHECK;
                        end else begin
                            r_phase <= PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        r_xor <= r_xor ^ i_rx_byte;
                        r_idx <= idx_inc;
                        if (idx_inc == r_len) begin
                            r_phase <= PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        r_phase <= PH_HUNT;
                    end
                    default: begin
                        r_phase <= PH_HUNT;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sofrx_buf.sv @@
// Two-bank payload buffer and two-entry frame queue between parser and drain.
// Bank i holds the payload of queue slot i. Depends on sofrx_pkg.
`default_nettype none

module sofrx_buf #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  sofrx_pkg::t_pl_wr          i_pl_wr,
    input  sofrx_pkg::t_frame_push     i_push,
    input  sofrx_pkg::t_drain_req      i_drain,
    output sofrx_pkg::t_fq_stat        o_stat,
    output logic [7:0]                 o_rd_data
);
    import sofrx_pkg::*;

    localparam int IW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int DEPTH = 2 << IW;

    logic [7:0]  r_mem [0:DEPTH-1];
    t_frame_desc r_desc [0:1];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic [7:0]  r_rd_data;

    always_comb begin
        o_stat.full  = (r_count == 2'd2);
        o_stat.empty = (r_count == 2'd0);
        o_stat.wbank = r_wptr;
        o_stat.head  = r_desc[r_rptr];
    end

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_pl_wr.en) begin
            r_mem[{i_pl_wr.bank, i_pl_wr.idx[IW-1:0]}] <= i_pl_wr.data;
        end
        r_rd_data <= r_mem[{r_rptr, i_drain.rd_idx[IW-1:0]}];
        if (i_push.valid) begin
            r_desc[r_wptr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= ~r_wptr;
            end
            if (i_drain.pop) begin
                r_rptr <= ~r_rptr;
            end
            unique case ({i_push.valid, i_drain.pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sofrx_back.sv @@
// Drain sequencer: walks each queued frame's payload out of the buffer and
// holds one result word on the output registers. Depends on sofrx_pkg.
`default_nettype none

module sofrx_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  sofrx_pkg::t_fq_stat    i_stat,
    input  wire  [7:0]             i_rd_data,
    input  wire                    i_pop,
    output sofrx_pkg::t_drain_req  o_drain,
    output logic                   o_empty,
    output logic [7:0]             o_frame_type,
    output logic [7:0]             o_device_id,
    output logic [5:0]             o_payload_length,
    output logic [7:0]             o_payload_byte,
    output logic                   o_byte_valid,
    output logic                   o_last
);
    import sofrx_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RD   = 2'd1,
        S_LD   = 2'd2,
        S_OUT  = 2'd3
    } t_state;

    t_state           r_state;
    logic [LEN_W-1:0] r_idx;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_type;
    logic [7:0]       r_id;
    logic [7:0]       r_byte;
    logic             r_valid;
    logic             r_last;

    logic [LEN_W-1:0] idx_inc;
    logic             take;

    assign idx_inc = r_idx + 1'b1;
    assign take    = (r_state == S_OUT) && i_pop;

    always_comb begin
        o_drain.pop    = take && r_last;
        o_drain.rd_idx = r_idx;
    end

    assign o_empty          = (r_state != S_OUT);
    assign o_frame_type     = r_type;
    assign o_device_id      = r_id;
    assign o_payload_length = r_len[5:0];
    assign o_payload_byte   = r_byte;
    assign o_byte_valid     = r_valid;
    assign o_last           = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_last  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_stat.empty) begin
                        r_type <= i_stat.head.frame_type;
                        r_id   <= i_stat.head.device_id;
                        r_len  <= i_stat.head.length;
                        r_idx  <= '0;
                        // zero-length frame: one word with no payload byte
                        if (i_stat.head.length == '0) begin
                            r_byte  <= 8'd0;
                            r_valid <= 1'b0;
                            r_last  <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    r_byte  <= i_rd_data;
                    r_valid <= 1'b1;
                    r_last  <= (idx_inc == r_len);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_pop) begin
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= idx_inc;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sof_length_frame_receiver.sv @@
// Top level of the start-of-frame/length frame receiver with XOR check.
// Instantiates sofrx_front, sofrx_buf and sofrx_back; depends on sofrx_pkg.
//
// Input: one received byte per word on i_rx_byte, taken when push is high and
// full is low. The parser takes one byte per cycle while not full. full rises
// only while two checked frames await draining (both payload banks in use).
// Output: a frame that passes its XOR check comes out as a run of words, one
// per payload byte, with type, ID and length on every word and o_last on the
// final one; a zero-length frame gives a single word with o_byte_valid low.
// The oldest word is on the result ports while empty is low; pop takes it.
// With the drain idle, the first word of a frame shows once its check byte is
// taken and the drain has passed its idle, read and load states (idle only for
// a zero-length frame). Each following word passes read and load after the
// previous pop, set by the registered buffer read; a last pop returns to idle.
// While the receiver holds pop low, the current word holds and the parser
// keeps taking bytes until two finished frames are queued.
// Reset (i_rst_n, synchronous, active low) returns the parser to hunting, sets
// start_byte to 0xAA and max_length to 32, and empties the frame queue.
// Configuration: i_cfg_we with i_cfg_idx 0 (start_byte) or 1 (max_length).
`default_nettype none

module sof_length_frame_receiver #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire  [7:0] i_cfg_wdata,
    input  wire        push,
    output logic       full,
    input  wire  [7:0] i_rx_byte,
    output logic       empty,
    input  wire        pop,
    output logic [7:0] o_frame_type,
    output logic [7:0] o_device_id,
    output logic [5:0] o_payload_length,
    output logic [7:0] o_payload_byte,
    output logic       o_byte_valid,
    output logic       o_last
);
    import sofrx_pkg::*;

    t_pl_wr      pl_wr;
    t_frame_push fq_push;
    t_fq_stat    fq_stat;
    t_drain_req  drain;
    logic [7:0]  rd_data;
    logic        accept;

    assign full   = fq_stat.full;
    assign accept = push && !fq_stat.full;

    sofrx_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_bank      (fq_stat.wbank),
        .o_pl_wr     (pl_wr),
        .o_push      (fq_push)
    );

    sofrx_buf #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pl_wr   (pl_wr),
        .i_push    (fq_push),
        .i_drain   (drain),
        .o_stat    (fq_stat),
        .o_rd_data (rd_data)
    );

    sofrx_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_stat           (fq_stat),
        .i_rd_data        (rd_data),
        .i_pop            (pop),
        .o_drain          (drain),
        .o_empty          (empty),
        .o_frame_type     (o_frame_type),
        .o_device_id      (o_device_id),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_byte_valid     (o_byte_valid),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

@@ sim/sofrx_frame_checker.sv @@
// Scoreboard for the start-of-frame/length receiver: watches the config port,
// the byte input and the word output, predicts every word, and compares.
// Depends on sofrx_pkg for the register indexes.
`default_nettype none

module sofrx_frame_checker #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire  [7:0] i_cfg_wdata,
    input  wire        i_push,
    input  wire        i_full,
    input  wire  [7:0] i_rx_byte,
    input  wire        i_empty,
    input  wire        i_pop,
    input  wire  [7:0] i_frame_type,
    input  wire  [7:0] i_device_id,
    input  wire  [5:0] i_payload_length,
    input  wire  [7:0] i_payload_byte,
    input  wire        i_byte_valid,
    input  wire        i_last,
    output int         o_words_pending,
    output int         o_fail_count
);
    import sofrx_pkg::*;

    typedef enum logic [2:0] {
        HUNT,
        GET_TYPE,
        GET_ID,
        GET_LEN_LO,
        GET_LEN_HI,
        GET_DATA,
        GET_CHECK
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] frame_type;
        logic [7:0] device_id;
        logic [5:0] length;
        logic [7:0] data;
        logic       byte_valid;
        logic       last;
    } t_rx_word;

    // Shadow registers and parser state
    logic [7:0]   start_val;
    logic [5:0]   max_len;
    t_parse_phase phase;
    logic [7:0]   ftype;
    logic [7:0]   dev_id;
    logic [15:0]  flen;
    logic [6:0]   idx;
    logic [7:0]   rx_xor;
    logic [7:0]   payload [MAX_PAYLOAD];
    t_rx_word     frame_words [$];

    function automatic string word_str(input t_rx_word w);
        return $sformatf("type=%02h id=%02h len=%0d byte=%02h valid=%0b last=%0b",
                         w.frame_type, w.device_id, w.length, w.data, w.byte_valid,
                         w.last);
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        int       limit;
        t_rx_word w;
        case (phase)
            HUNT: begin
                if (b == start_val) begin
                    rx_xor = 8'h00;
                    phase  = GET_TYPE;
                end
            end
            GET_TYPE: begin
                ftype  = b;
                rx_xor ^= b;
                phase  = GET_ID;
            end
            GET_ID: begin
                dev_id = b;
                rx_xor ^= b;
                phase  = GET_LEN_LO;
            end
            GET_LEN_LO: begin
                flen   = {8'h00, b};
                rx_xor ^= b;
                phase  = GET_LEN_HI;
            end
            GET_LEN_HI: begin
                flen[15:8] = b;
                rx_xor ^= b;
                idx = '0;
                limit = (int'(max_len) < MAX_PAYLOAD) ? int'(max_len) : MAX_PAYLOAD;
                // drop an oversized frame without waiting for its check byte
                if (int'(flen) > limit)
                    phase = HUNT;
                else if (flen == 16'd0)
                    phase = GET_CHECK;
                else
                    phase = GET_DATA;
            end
            GET_DATA: begin
                if (int'(idx) < MAX_PAYLOAD)
                    payload[idx] = b;
                rx_xor ^= b;
                idx = idx + 7'd1;
                if (int'(idx) >= int'(flen))
                    phase = GET_CHECK;
            end
            GET_CHECK: begin
                if (rx_xor == b) begin
                    if (flen == 16'd0) begin
                        w = '{frame_type: ftype, device_id: dev_id, length: 6'd0,
                              data: 8'h00, byte_valid: 1'b0, last: 1'b1};
                        frame_words.push_back(w);
                    end else begin
                        for (int i = 0; i < int'(flen) && i < MAX_PAYLOAD; i++) begin
                            w = '{frame_type: ftype, device_id: dev_id,
                                  length: flen[5:0], data: payload[i],
                                  byte_valid: 1'b1, last: (i + 1 == int'(flen))};
                            frame_words.push_back(w);
                        end
                    end
                end
                phase = HUNT;
            end
            default: phase = HUNT;
        endcase
    endtask

    task automatic check_word();
        t_rx_word got;
        t_rx_word want;
        got = '{frame_type: i_frame_type, device_id: i_device_id,
                length: i_payload_length, data: i_payload_byte,
                byte_valid: i_byte_valid, last: i_last};
        if (frame_words.size() == 0) begin
            $display("%0t: word popped with none expected, got %s", $time, word_str(got));
            o_fail_count = o_fail_count + 1;
        end else begin
            want = frame_words.pop_front();
            if (got !== want) begin
                $display("%0t: word mismatch, expected %s, got %s", $time,
                         word_str(want), word_str(got));
                o_fail_count = o_fail_count + 1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_val = START_BYTE_RST;
            max_len   = MAX_LENGTH_RST;
            phase     = HUNT;
            ftype     = 8'h00;
            dev_id    = 8'h00;
            flen      = 16'h0000;
            idx       = '0;
            rx_xor    = 8'h00;
            frame_words.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_START_BYTE)
                    start_val = i_cfg_wdata;
                else
                    max_len = i_cfg_wdata[5:0];
            end
            if (i_push && !i_full)
                parse_byte(i_rx_byte);
            if (i_pop && !i_empty)
                check_word();
        end
        o_words_pending = frame_words.size();
    end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Top of the receiver testbench: clock, reset, byte and word traffic with random
// idling, config phases and the verdict. Depends on sofrx_pkg,
// sof_length_frame_receiver and sofrx_frame_checker.
`default_nettype none

module testbench;
    import sofrx_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 500;
    localparam int FLUSH_BYTES   = 34;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_wdata;
    logic       push;
    logic [7:0] i_rx_byte;
    logic       pop;
    wire        full;
    wire        empty;
    wire  [7:0] o_frame_type;
    wire  [7:0] o_device_id;
    wire  [5:0] o_payload_length;
    wire  [7:0] o_payload_byte;
    wire        o_byte_valid;
    wire        o_last;

    int         words_pending;
    int         fail_count;
    int         cycles = 0;
    bit         no_idle = 1'b0;
    bit         rx_hold = 1'b0;
    logic [7:0] start_val;
    logic [5:0] max_len;

    // Noise, good zero-length frame, payload holding the start byte,
    // oversized length, bad check byte
    logic [7:0] directed_bytes [26] = '{
        8'hFF,
        8'hAA, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
        8'hAA, 8'hFF, 8'h00, 8'h02, 8'h00, 8'hAA, 8'h55, 8'h02,
        8'hAA, 8'h01, 8'h02, 8'h21, 8'h00,
        8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01
    };

    sof_length_frame_receiver #(.MAX_PAYLOAD(32)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .push             (push),
        .full             (full),
        .i_rx_byte        (i_rx_byte),
        .empty            (empty),
        .pop              (pop),
        .o_frame_type     (o_frame_type),
        .o_device_id      (o_device_id),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_byte_valid     (o_byte_valid),
        .o_last           (o_last)
    );

    sofrx_frame_checker #(.MAX_PAYLOAD(32)) frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_push           (push),
        .i_full           (full),
        .i_rx_byte        (i_rx_byte),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_frame_type     (o_frame_type),
        .i_device_id      (o_device_id),
        .i_payload_length (o_payload_length),
        .i_payload_byte   (o_payload_byte),
        .i_byte_valid     (o_byte_valid),
        .i_last           (o_last),
        .o_words_pending  (words_pending),
        .o_fail_count     (fail_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none while a burst is on
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] data_byte();
        if ($urandom_range(0, 99) < 15)
            return start_val;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] non_start_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == start_val);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_gap();
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full !== 1'b0);
    endtask

    // Send one frame (good, bad check, oversized, cut short) or a noise run;
    // count only frame bytes
    task automatic send_frame(inout int sent);
        logic [7:0] frame [$];
        logic [7:0] csum;
        int         kind;
        int         len;
        int         limit;
        int         r;
        kind  = $urandom_range(0, 99);
        limit = int'(max_len);
        if (kind < 8) begin
            repeat ($urandom_range(1, 5)) send_byte(non_start_byte());
            return;
        end
        if (kind < 16) begin
            if ($urandom_range(0, 1))
                len = $urandom_range(limit + 1, 255);
            else
                len = ($urandom_range(1, 255) << 8) | $urandom_range(0, 255);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 15)
                len = 0;
            else if (r < 30)
                len = limit;
            else
                len = $urandom_range(0, limit);
        end
        frame.push_back(start_val);
        frame.push_back(data_byte());
        frame.push_back(data_byte());
        frame.push_back(len[7:0]);
        frame.push_back(len[15:8]);
        csum = frame[1] ^ frame[2] ^ frame[3] ^ frame[4];
        if (len <= limit) begin
            repeat (len) begin
                frame.push_back(data_byte());
                csum ^= frame[frame.size() - 1];
            end
            if (kind >= 16 && kind < 24)
                csum ^= 8'(1 << $urandom_range(0, 7));
            frame.push_back(csum);
            // cut short: the next frame's bytes land inside this one
            if (kind >= 24 && kind < 32)
                frame = frame[0:$urandom_range(1, frame.size() - 2)];
        end
        foreach (frame[i]) send_byte(frame[i]);
        sent += frame.size();
    endtask

    task automatic run_random(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) == 0)
                no_idle = !no_idle;
            send_frame(sent);
        end
        no_idle = 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (words_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Walk the parser back to hunting, drain, then write both registers
    task automatic reconfigure(input logic [7:0] sb, input logic [5:0] ml);
        logic [7:0] fill;
        fill = (start_val == 8'h01) ? 8'h02 : 8'h01;
        repeat (FLUSH_BYTES) send_byte(fill);
        push <= 1'b0;
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_START_BYTE;
        i_cfg_wdata <= sb;
        @(posedge i_clk);
        i_cfg_idx   <= REG_MAX_LENGTH;
        i_cfg_wdata <= {2'b00, ml};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        start_val = sb;
        max_len   = ml;
    endtask

    // Word receiver: random pops, one long hold-off on request
    initial begin
        int gap;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            gap = idle_gap();
            if (gap == 0) begin
                pop <= 1'b1;
                @(posedge i_clk);
            end else begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_START_BYTE;
        i_cfg_wdata <= 8'h00;
        push        <= 1'b0;
        i_rx_byte   <= 8'h00;
        start_val = START_BYTE_RST;
        max_len   = MAX_LENGTH_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        run_random(50);

        reconfigure(8'h00, 6'd0);
        run_random(40);

        reconfigure(8'hFF, 6'd32);
        rx_hold = 1'b1;
        run_random(100);

        reconfigure(8'($urandom_range(0, 255)), 6'($urandom_range(1, 31)));
        run_random(34);

        reconfigure(8'hAA, 6'd1);
        run_random(30);

        push <= 1'b0;
        wait_drained();
        if (fail_count == 0 && words_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
